FILE: hw/rtl/bba_pkg.sv
// bba_pkg: sizes, codes and state encoding of the bitmap block allocator.
// Used by the channel interfaces and the top level; depends on nothing.
package bba_pkg;

  // Pool depth in blocks (2 .. 4096).
  localparam int NUM_BLOCKS = 256;

  // Free map is held as rows of MAP_W bits in a RAM.
  localparam int MAP_W     = 32;
  localparam int MAP_BW    = 5;
  localparam int MAP_ROWS  = (NUM_BLOCKS + MAP_W - 1) / MAP_W;
  localparam int ROW_AW    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int IDX_W     = $clog2(NUM_BLOCKS);

  // Field widths.
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int COUNT_W   = 9;
  localparam int CNT_W     = 32;
  localparam int STEP_W    = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

  localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = '0;
  localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE   = 16'd16;
  localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT  = 9'd256;

  // Request opcodes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_DIV,
    S_FREE_CHK,
    S_FREE_RD,
    S_FREE_WR,
    S_FINISH
  } state_t;

endpackage

FILE: hw/rtl/bba_req_if.sv
// bba_req_if: request channel (valid/ready plus request word).
// Depends on bba_pkg for field widths.
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [bba_pkg::ADDR_W-1:0]   request_size;
  logic [bba_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output func, output request_size, output address,
                  input ready);
  modport sink   (input valid, input func, input request_size, input address,
                  output ready);
endinterface

FILE: hw/rtl/bba_rsp_if.sv
// bba_rsp_if: response channel (valid/ready plus response word).
// Depends on bba_pkg for field widths and the status code type.
interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  bba_pkg::status_t             status;
  logic [bba_pkg::ADDR_W-1:0]   block_address;
  logic [bba_pkg::CNT_W-1:0]    total_allocs;

  modport source (output valid, output status, output block_address,
                  output total_allocs, input ready);
  modport sink   (input valid, input status, input block_address,
                  input total_allocs, output ready);
endinterface

FILE: hw/rtl/bba_ram.sv
// bba_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module bba_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bitmap_block_allocator_top.sv
// bitmap_block_allocator_top: fixed-size block allocator over a free bitmap.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and bba_ram.
//
// Hands out fixed-size blocks from a pool of up to NUM_BLOCKS blocks. An
// allocate word (func 0) larger than block_size answers "size too large";
// otherwise the lowest free block of the active pool (min(block_count,
// NUM_BLOCKS) blocks) is marked used and base_address + index * block_size
// comes back, or "no free block". A free word (func 1) is taken only for an
// address that is block-aligned inside the active pool, else "bad address";
// freeing an already free block is ok. Every request word gives exactly one
// response word carrying the running, wrapping count of allocations. The
// free map lives in a RAM of 32-bit rows. After reset a clearing pass marks
// every block free, one row per cycle; no request is taken meanwhile, and
// configuration writes always are. One request is processed at a time and
// ready is low while it runs. A rejected allocate, an allocate on an empty
// pool or a free with block_size 0 goes straight to the final step. An
// allocate reads and checks the map RAM one row at a time until it finds a
// free block, which is then marked used and its address formed in a
// multiply step, or until it runs out of rows. A free first runs the radix-2
// divider that splits the offset into block index and remainder, one
// quotient bit per cycle, then checks the result and, when the address is
// taken, reads and writes back its map row. The response sits in an output
// register, so a stalled sink holds the sequencer only at its final step.
module bitmap_block_allocator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]   cfg_data,
  bba_req_if.sink                          req,
  bba_rsp_if.source                        rsp
);

  // Configuration registers
  logic [bba_pkg::ADDR_W-1:0]  base_address;
  logic [bba_pkg::SIZE_W-1:0]  block_size;
  logic [bba_pkg::COUNT_W-1:0] block_count;

  // Sequencer and datapath
  bba_pkg::state_t             state, state_next;
  logic [bba_pkg::ROW_AW-1:0]  row;
  logic [bba_pkg::IDX_W-1:0]   idx;
  logic [bba_pkg::ADDR_W-1:0]  prod;
  logic [bba_pkg::SIZE_W-1:0]  rem;
  logic [bba_pkg::ADDR_W-1:0]  quo;
  logic [bba_pkg::STEP_W-1:0]  step;
  bba_pkg::status_t            status;
  logic                        grant;
  logic [bba_pkg::CNT_W-1:0]   alloc_counter;

  // Output register
  logic                        out_valid;
  bba_pkg::status_t            out_status;
  logic [bba_pkg::ADDR_W-1:0]  out_addr;
  logic [bba_pkg::CNT_W-1:0]   out_count;

  // Map RAM
  logic                        ram_we;
  logic [bba_pkg::MAP_W-1:0]   ram_wdata;
  logic [bba_pkg::MAP_W-1:0]   ram_rdata;

  // Combinational helpers
  logic [31:0]                 n_active;
  logic [31:0]                 row_base;
  logic [31:0]                 row_left;
  logic [bba_pkg::MAP_W-1:0]   row_mask;
  logic [bba_pkg::MAP_W-1:0]   masked;
  logic                        found;
  logic [bba_pkg::MAP_BW-1:0]  sel_bit;
  logic                        more_rows;
  logic [bba_pkg::SIZE_W:0]    trial;
  logic [bba_pkg::SIZE_W:0]    trial_sub;
  logic                        trial_ge;
  logic [bba_pkg::IDX_W+bba_pkg::SIZE_W-1:0] prod_w;
  logic                        in_take;
  logic                        out_load;
  logic                        last_row;

  bba_ram #(
    .WIDTH (bba_pkg::MAP_W),
    .DEPTH (bba_pkg::MAP_ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row),
    .wdata (ram_wdata),
    .raddr (row),
    .rdata (ram_rdata)
  );

  assign req.ready         = (state == bba_pkg::S_IDLE);
  assign in_take           = req.valid && req.ready;
  assign out_load          = (state == bba_pkg::S_FINISH) && (!out_valid || rsp.ready);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.block_address = out_addr;
  assign rsp.total_allocs  = out_count;

  assign last_row = (row == bba_pkg::ROW_AW'(bba_pkg::MAP_ROWS - 1));

  // Active pool size
  always_comb begin
    if (32'(block_count) > 32'(bba_pkg::NUM_BLOCKS)) begin
      n_active = 32'(bba_pkg::NUM_BLOCKS);
    end else begin
      n_active = 32'(block_count);
    end
  end

  // Row scan: mask off blocks beyond the active pool, pick lowest free bit
  always_comb begin
    row_base  = 32'(row) << bba_pkg::MAP_BW;
    row_left  = n_active - row_base;
    if (row_left >= 32'(bba_pkg::MAP_W)) begin
      row_mask = '1;
    end else begin
      row_mask = (bba_pkg::MAP_W'(1) << row_left[bba_pkg::MAP_BW-1:0]) - bba_pkg::MAP_W'(1);
    end
    masked    = ram_rdata & row_mask;
    found     = |masked;
    sel_bit   = '0;
    for (int b = bba_pkg::MAP_W - 1; b >= 0; b--) begin
      if (masked[b]) begin
        sel_bit = bba_pkg::MAP_BW'(b);
      end
    end
    more_rows = (row_base + 32'(bba_pkg::MAP_W)) < n_active;
  end

  // Divider step: one quotient bit per cycle
  always_comb begin
    trial     = {rem, quo[bba_pkg::ADDR_W-1]};
    trial_sub = trial - {1'b0, block_size};
    trial_ge  = (trial >= {1'b0, block_size});
  end

  assign prod_w = (bba_pkg::IDX_W + bba_pkg::SIZE_W)'(idx) *
                  (bba_pkg::IDX_W + bba_pkg::SIZE_W)'(block_size);

  // Next state and RAM write control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wdata  = ram_rdata;
    unique case (state)
      bba_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (last_row) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (in_take) begin
          if (req.func == bba_pkg::FUNC_ALLOC) begin
            if (req.request_size > 32'(block_size) || n_active == 32'd0) begin
              state_next = bba_pkg::S_FINISH;
            end else begin
              state_next = bba_pkg::S_SCAN_RD;
            end
          end else begin
            if (block_size == '0) begin
              state_next = bba_pkg::S_FINISH;
            end else begin
              state_next = bba_pkg::S_DIV;
            end
          end
        end
      end
      bba_pkg::S_SCAN_RD: begin
        state_next = bba_pkg::S_SCAN_CHK;
      end
      bba_pkg::S_SCAN_CHK: begin
        if (found) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata & ~(bba_pkg::MAP_W'(1) << sel_bit);
          state_next = bba_pkg::S_MUL;
        end else if (more_rows) begin
          state_next = bba_pkg::S_SCAN_RD;
        end else begin
          state_next = bba_pkg::S_FINISH;
        end
      end
      bba_pkg::S_MUL: begin
        state_next = bba_pkg::S_FINISH;
      end
      bba_pkg::S_DIV: begin
        if (step == '1) begin
          state_next = bba_pkg::S_FREE_CHK;
        end
      end
      bba_pkg::S_FREE_CHK: begin
        if (rem == '0 && quo < n_active) begin
          state_next = bba_pkg::S_FREE_RD;
        end else begin
          state_next = bba_pkg::S_FINISH;
        end
      end
      bba_pkg::S_FREE_RD: begin
        state_next = bba_pkg::S_FREE_WR;
      end
      bba_pkg::S_FREE_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata | (bba_pkg::MAP_W'(1) << quo[bba_pkg::MAP_BW-1:0]);
        state_next = bba_pkg::S_FINISH;
      end
      bba_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= bba_pkg::RST_BASE_ADDRESS;
      block_size   <= bba_pkg::RST_BLOCK_SIZE;
      block_count  <= bba_pkg::RST_BLOCK_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bba_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data[bba_pkg::ADDR_W-1:0];
        bba_pkg::CFG_BLOCK_SIZE:   block_size   <= cfg_data[bba_pkg::SIZE_W-1:0];
        bba_pkg::CFG_BLOCK_COUNT:  block_count  <= cfg_data[bba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      row           <= '0;
      alloc_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        bba_pkg::S_INIT: begin
          row <= row + bba_pkg::ROW_AW'(1);
        end
        bba_pkg::S_IDLE: begin
          row   <= '0;
          grant <= 1'b0;
          rem   <= '0;
          quo   <= req.address - base_address;
          step  <= '0;
          if (req.func == bba_pkg::FUNC_ALLOC) begin
            if (req.request_size > 32'(block_size)) begin
              status <= bba_pkg::ST_TOO_LARGE;
            end else begin
              status <= bba_pkg::ST_NO_FREE;
            end
          end else begin
            status <= bba_pkg::ST_BAD_ADDR;
          end
        end
        bba_pkg::S_SCAN_RD: ;
        bba_pkg::S_SCAN_CHK: begin
          if (found) begin
            idx           <= bba_pkg::IDX_W'(row_base | 32'(sel_bit));
            alloc_counter <= alloc_counter + bba_pkg::CNT_W'(1);
            status        <= bba_pkg::ST_OK;
            grant         <= 1'b1;
          end else if (more_rows) begin
            row <= row + bba_pkg::ROW_AW'(1);
          end
        end
        bba_pkg::S_MUL: begin
          prod <= 32'(prod_w);
        end
        bba_pkg::S_DIV: begin
          rem  <= trial_ge ? trial_sub[bba_pkg::SIZE_W-1:0] : trial[bba_pkg::SIZE_W-1:0];
          quo  <= {quo[bba_pkg::ADDR_W-2:0], trial_ge};
          step <= step + bba_pkg::STEP_W'(1);
        end
        bba_pkg::S_FREE_CHK: begin
          row <= bba_pkg::ROW_AW'(quo >> bba_pkg::MAP_BW);
        end
        bba_pkg::S_FREE_RD: ;
        bba_pkg::S_FREE_WR: begin
          status <= bba_pkg::ST_OK;
        end
        bba_pkg::S_FINISH: begin
          if (out_load) begin
            out_status <= status;
            out_addr   <= grant ? (base_address + prod) : '0;
            out_count  <= alloc_counter;
          end
        end
        default: ;
      endcase
    end
  end

  // A response word only appears after the final sequencer step.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == bba_pkg::S_FINISH))
    else $error("response raised outside FINISH");

  // The allocation count moves only when the scan grants a block.
  a_count_on_grant: assert property (@(posedge clk) disable iff (rst)
    (state != bba_pkg::S_INIT && alloc_counter != $past(alloc_counter)) |->
      ($past(state == bba_pkg::S_SCAN_CHK) && $past(found)))
    else $error("allocation count changed without a grant");

  // A failed request never carries an address.
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != bba_pkg::ST_OK) |-> (out_addr == '0))
    else $error("failed response with nonzero address");

  // A block is only released for an aligned offset.
  a_free_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_FREE_RD) |-> (rem == '0 && block_size != '0))
    else $error("free of an unaligned offset");

endmodule

FILE: verif/bitmap_block_allocator_top_tb.sv
// bitmap_block_allocator_top_tb: self-checking bench for the bitmap block allocator.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and the bitmap_block_allocator_top RTL.
// An in-bench model of the free map predicts each response word.
module bitmap_block_allocator_top_tb;
  import bba_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 4;      // quiet cycles before a register write
  localparam int DRAIN_CYCLES    = 40;     // quiet cycles after the last response
  localparam int RSP_HOLD_CYCLES = 400;    // long sink stall for the backpressure test
  localparam int PRESSURE_WORDS  = 16;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_WORDS     = 200;
  localparam int RUN_LIMIT       = 10_000_000;  // time limit for the watchdog

  // Response sink behavior, re-chosen every stretch of cycles.
  typedef enum int {
    SINK_OPEN,      // always ready
    SINK_COIN,      // ready on a coin toss
    SINK_PERIODIC,  // ready once per period
    SINK_SPARSE     // mostly ready, rare stalls
  } sink_mode_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  total_allocs;
  } alloc_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Allocator model: its own copy of the free map, counter and registers.
  // ---------------------------------------------------------------------------
  bit [NUM_BLOCKS-1:0]  pool_free;     // 1 = block free
  logic [CNT_W-1:0]     alloc_total;
  logic [ADDR_W-1:0]    cfg_base;
  logic [SIZE_W-1:0]    cfg_bsize;
  logic [COUNT_W-1:0]   cfg_count;

  alloc_rsp_t pending_results[$];      // predicted response words, oldest first
  alloc_rsp_t want;

  int error_count;
  int words_sent;
  int settings_used;
  int status_seen[4];
  int hold_requests;                   // bumped by a test, picked up by the sink
  int burst_left;

  task automatic model_reset();
    pool_free   = '1;
    alloc_total = '0;
    cfg_base    = RST_BASE_ADDRESS;
    cfg_bsize   = RST_BLOCK_SIZE;
    cfg_count   = RST_BLOCK_COUNT;
  endtask

  // Active pool is min(block_count, NUM_BLOCKS).
  function automatic int unsigned pool_blocks();
    if (cfg_count > NUM_BLOCKS) return NUM_BLOCKS;
    return cfg_count;
  endfunction

  // Applies one request to the model and returns the response word it yields.
  function automatic alloc_rsp_t predict_request(input logic op,
                                                 input logic [ADDR_W-1:0] size,
                                                 input logic [ADDR_W-1:0] addr);
    alloc_rsp_t        r;
    int unsigned       pool;
    int unsigned       i;
    logic [ADDR_W-1:0] bsize32;
    logic [ADDR_W-1:0] offs;
    logic [ADDR_W-1:0] slot;
    bit                found;
    pool            = pool_blocks();
    bsize32         = cfg_bsize;
    r.block_address = '0;
    found           = 1'b0;
    if (op == FUNC_ALLOC) begin
      if (size > bsize32) begin
        r.status = ST_TOO_LARGE;
      end else begin
        r.status = ST_NO_FREE;
        for (i = 0; i < pool; i++) begin
          if (!found && pool_free[i]) begin
            found           = 1'b1;
            pool_free[i]    = 1'b0;
            alloc_total     = alloc_total + 1'b1;
            slot            = i;
            r.block_address = cfg_base + slot * bsize32;  // wraps mod 2^32
            r.status        = ST_OK;
          end
        end
      end
    end else begin
      // Offset taken mod 2^32 so wrapped pools free cleanly; block 0 is legal.
      r.status = ST_BAD_ADDR;
      offs     = addr - cfg_base;
      if (bsize32 != 0 && (offs % bsize32) == 0) begin
        slot = offs / bsize32;
        if (slot < pool) begin
          pool_free[slot] = 1'b1;       // double free is fine
          r.status        = ST_OK;
        end
      end
    end
    r.total_allocs = alloc_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: drive at the falling edge, see acceptance at the rising edge.
  // valid is left high after a word so back-to-back words need one assignment.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic op, input logic [ADDR_W-1:0] size,
                           input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.func         <= op;
    req_ch.request_size <= size;
    req_ch.address      <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_request(op, size, addr));
    words_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Bursts of random length, gaps from none up to past a full free latency.
  task automatic paced_send(input logic op, input logic [ADDR_W-1:0] size,
                            input logic [ADDR_W-1:0] addr);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(4, 12);
        default: gap = $urandom_range(13, 45);
      endcase
      idle_cycles(gap);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_word(op, size, addr);
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_BASE_ADDRESS: cfg_base  = data;
      CFG_BLOCK_SIZE:   cfg_bsize = data[SIZE_W-1:0];
      CFG_BLOCK_COUNT:  cfg_count = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Registers change only with the block idle.
  task automatic configure_pool(input logic [CFG_DATA_W-1:0] base,
                                input logic [CFG_DATA_W-1:0] size_word,
                                input logic [CFG_DATA_W-1:0] count_word);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_BLOCK_SIZE, size_word);
    write_reg(CFG_BLOCK_COUNT, count_word);
    settings_used++;
  endtask

  // Mostly well-formed traffic: fitting allocates and frees of live blocks,
  // with some oversize requests, double frees and stray addresses mixed in.
  // Ignored fields always carry random bits.
  task automatic random_word(output logic op, output logic [ADDR_W-1:0] size,
                             output logic [ADDR_W-1:0] addr);
    int unsigned       pool;
    int unsigned       used;
    int unsigned       pick;
    int unsigned       i;
    int unsigned       alloc_pct;
    logic [ADDR_W-1:0] bsize32;
    bit                hit;
    pool    = pool_blocks();
    bsize32 = cfg_bsize;
    used    = 0;
    for (i = 0; i < pool; i++) if (!pool_free[i]) used++;
    // Lean toward frees as the pool fills so it keeps cycling.
    alloc_pct = (used == 0) ? 80 : ((used == pool) ? 30 : 55);
    size = $urandom;
    addr = $urandom;
    if ($urandom_range(0, 99) < alloc_pct) begin
      op = FUNC_ALLOC;
      case ($urandom_range(0, 19))
        0:       ;                                   // full-width random size
        1:       size = bsize32 + $urandom_range(1, 16);
        2:       size = bsize32;
        default: size = $urandom_range(0, bsize32);
      endcase
    end else begin
      op   = FUNC_FREE;
      pick = (pool > 0) ? $urandom_range(0, pool - 1) : 0;
      hit  = 1'b0;
      for (i = 0; i < pool; i++) begin
        if (!hit && !pool_free[(pick + i) % pool]) begin
          hit  = 1'b1;
          pick = (pick + i) % pool;
        end
      end
      case ($urandom_range(0, 19))
        0:       ;                                   // stray address
        1:       addr = cfg_base + pick * bsize32 + 1;
        2:       addr = cfg_base + pool * bsize32;   // one past the pool
        3:       addr = cfg_base - bsize32;
        4, 5:    addr = cfg_base + ((pool > 0) ? $urandom_range(0, pool - 1) : 0) * bsize32;
        default: addr = cfg_base + pick * bsize32;   // live block, else a double free
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response checking against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected response word: status %0d block_address %h total_allocs %0d",
               rsp_ch.status, rsp_ch.block_address, rsp_ch.total_allocs);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[int'(want.status)]++;
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.block_address !== want.block_address) begin
          $error("block_address: expected %h, actual %h",
                 want.block_address, rsp_ch.block_address);
          error_count++;
        end
        if (rsp_ch.total_allocs !== want.total_allocs) begin
          $error("total_allocs: expected %0d, actual %0d",
                 want.total_allocs, rsp_ch.total_allocs);
          error_count++;
        end
      end
    end
  end

  // Response sink: stall pattern of its own, plus a long hold on request.
  initial begin : rsp_sink
    sink_mode_t mode;
    int         span;
    int         period;
    int         tick;
    int         hold_left;
    int         hold_seen;
    logic       rdy;
    rsp_ch.ready <= 1'b0;
    mode      = SINK_OPEN;
    span      = 0;
    period    = 2;
    tick      = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = RSP_HOLD_CYCLES;
      end
      if (span == 0) begin
        mode   = sink_mode_t'($urandom_range(0, 3));
        span   = $urandom_range(16, 160);
        period = $urandom_range(2, 7);
      end
      span--;
      tick++;
      case (mode)
        SINK_OPEN:     rdy = 1'b1;
        SINK_COIN:     rdy = $urandom_range(0, 1);
        SINK_PERIODIC: rdy = ((tick % period) == 0);
        default:       rdy = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end
      rsp_ch.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset pool (base 0, 16-byte blocks, 256 blocks): size limits, block 0
  // free, double free, misaligned and out-of-pool addresses.
  task automatic test_default_pool();
    send_word(FUNC_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_word(FUNC_ALLOC, 32'd16, 32'd0);
    send_word(FUNC_ALLOC, 32'd17, 32'd0);
    send_word(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_word(FUNC_FREE, 32'hFFFF_FFFF, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'd5);
    send_word(FUNC_FREE, 32'd0, 32'd4096);
    send_word(FUNC_FREE, 32'd0, 32'hFFFF_FFFF);
  endtask

  // Two 1-byte blocks: run out, free one, get it back.
  task automatic test_pool_exhaustion();
    configure_pool(32'h0000_1000, 32'd1, 32'd2);
    send_word(FUNC_ALLOC, 32'd1, 32'd0);
    send_word(FUNC_ALLOC, 32'd0, 32'd0);
    send_word(FUNC_ALLOC, 32'd1, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'h0000_1001);
    send_word(FUNC_ALLOC, 32'd1, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'h0000_1000);
  endtask

  // Block size 0: only size 0 fits, every free is refused.
  task automatic test_zero_block_size();
    configure_pool(32'h0000_0040, 32'd0, 32'd4);
    send_word(FUNC_ALLOC, 32'd0, 32'd0);
    send_word(FUNC_ALLOC, 32'd1, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'h0000_0040);
  endtask

  // Block count 0: nothing to grant or free.
  task automatic test_empty_pool();
    configure_pool(32'h0000_0040, 32'd8, 32'd0);
    send_word(FUNC_ALLOC, 32'd0, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'h0000_0040);
  endtask

  // Largest block size near the top of the address space: grants wrap past 2^32
  // and freeing the wrapped addresses must still find the right blocks.
  task automatic test_address_wrap();
    configure_pool(32'hFFFF_0000, 32'h0000_FFFF, 32'd256);
    send_word(FUNC_ALLOC, 32'h0000_FFFF, 32'd0);
    send_word(FUNC_ALLOC, 32'd0, 32'd0);
    send_word(FUNC_ALLOC, 32'd1, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'h0000_FFFE);
    send_word(FUNC_FREE, 32'd0, 32'hFFFF_FFFF);
  endtask

  // Sink holds off for a long stretch while words keep coming, so the
  // response register fills and request ready drops.
  task automatic test_output_backpressure();
    int          k;
    logic        op;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    configure_pool(32'h0000_8000, 32'd64, 32'd16);
    hold_requests++;
    for (k = 0; k < PRESSURE_WORDS; k++) begin
      random_word(op, size, addr);
      send_word(op, size, addr);
    end
  endtask

  // Random traffic over a series of pool settings, extremes included.
  // Upper bits of narrow register writes carry junk that must be dropped.
  task automatic test_random_traffic();
    int                 p;
    int                 k;
    logic               op;
    logic [ADDR_W-1:0]  size;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  bsz;
    logic [COUNT_W-1:0] cnt;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      base = $urandom;
      bsz  = $urandom_range(1, 65535);
      cnt  = $urandom_range(1, NUM_BLOCKS);
      case (p)
        0: begin
          base = RST_BASE_ADDRESS;
          bsz  = RST_BLOCK_SIZE;
          cnt  = RST_BLOCK_COUNT;
        end
        1: begin
          bsz = 16'd1;
          cnt = 9'd8;
        end
        2: begin
          base = 32'hFFFF_FFFF;
          bsz  = 16'hFFFF;
          cnt  = NUM_BLOCKS;
        end
        3: ;
        4: begin
          bsz = $urandom_range(2, 64);
          cnt = $urandom_range(1, 16);
        end
        5: bsz = '0;
        6: cnt = '0;
        7: cnt = $urandom_range(NUM_BLOCKS + 1, 511);   // above the pool depth
        8: begin
          base = 32'hFFFF_FF00 | $urandom_range(0, 255);
          bsz  = $urandom_range(1, 255);
        end
        default: cnt = 9'd1;
      endcase
      configure_pool(base, ($urandom & 32'hFFFF_0000) | bsz,
                     ($urandom & 32'hFFFF_FE00) | cnt);
      for (k = 0; k < PHASE_WORDS; k++) begin
        random_word(op, size, addr);
        paced_send(op, size, addr);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_BASE_ADDRESS;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.func         <= FUNC_ALLOC;
    req_ch.request_size <= '0;
    req_ch.address      <= '0;
    error_count   = 0;
    words_sent    = 0;
    settings_used = 0;
    hold_requests = 0;
    burst_left    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    model_reset();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The clearing pass after reset keeps request ready low; send_word waits.
    test_default_pool();
    test_pool_exhaustion();
    test_zero_block_size();
    test_empty_pool();
    test_address_wrap();
    test_output_backpressure();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d request words over %0d pool settings, one %0d-cycle sink hold",
             words_sent, settings_used, RSP_HOLD_CYCLES);
    $display("Statuses: ok %0d, too large %0d, no free block %0d, bad address %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a lost response word.
  initial begin
    #RUN_LIMIT;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
